// ===== hw/rtl/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg: shared definitions for the run-length bitmap blit core
// Holds the request and response payload types, the register index codes, the
// pixel pipeline control types and the sequencer state type.
// ----------------------------------------------------------------------------
package rbb_pkg;

   // Default screen geometry.
   localparam int SCREEN_WIDTH_DEF  = 480;
   localparam int SCREEN_HEIGHT_DEF = 320;

   // Configuration port geometry and register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE_MODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_COLOR       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_COLOR      = 3'd6;

   // Request operation codes.
   localparam logic OP_RUN   = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Saturation limits.
   localparam logic [17:0] COUNT_MAX = 18'h3FFFF;
   localparam logic [15:0] ROW_MAX   = 16'hFFFF;

   // A zero image size stands for this many pixels.
   localparam logic [12:0] SIZE_ZERO_AS = 13'd4096;

   typedef struct packed {
      logic       op;
      logic [7:0] run_length;
      logic       last_run;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic        window_last;
      logic [17:0] pixels_drawn;
   } rsp_payload_type;

   // What a pixel in the address pipeline is for.
   typedef struct packed {
      logic is_run;
      logic wr_en;
      logic wr_bit;
   } pix_tag_type;

   // Control that travels with a pixel out of the address pipeline.
   typedef struct packed {
      logic        vld;
      logic        on_screen;
      pix_tag_type tag;
   } pix_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FETCH,
      ST_FETCH_ISSUE,
      ST_FETCH_WAIT,
      ST_DONE
   } blit_state_type;

endpackage

// ===== hw/rtl/rbb_screen_mem.sv =====
// ----------------------------------------------------------------------------
// rbb_screen_mem: 1-bit screen store
// Word-organized memory with a per-bit write mask and a registered read port.
// ----------------------------------------------------------------------------
module rbb_screen_mem #(
   parameter int DEPTH = 4800,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_mask,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] store_mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Masked write: only the selected bits of the word change.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < 32; i++) begin
            if (wr_mask[i]) begin
               store_mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rbb_addr_unit.sv =====
// ----------------------------------------------------------------------------
// rbb_addr_unit: shared pixel address pipeline
// Adds the image origin to an image position, clips against the screen and
// turns the screen position into a store word address and bit index. Two
// register stages; one pixel may enter every cycle.
// ----------------------------------------------------------------------------
module rbb_addr_unit
   import rbb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   localparam int XW           = $clog2(SCREEN_WIDTH),
   localparam int YW           = $clog2(SCREEN_HEIGHT),
   localparam int PIX_TOTAL    = SCREEN_WIDTH * SCREEN_HEIGHT,
   localparam int IDX_W        = $clog2(PIX_TOTAL),
   localparam int STORE_WORDS  = (PIX_TOTAL + 31) / 32,
   localparam int WORD_AW      = $clog2(STORE_WORDS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  pix_tag_type        in_tag,
   input  logic [11:0]        base_x,
   input  logic [11:0]        base_y,
   input  logic [11:0]        off_x,
   input  logic [15:0]        off_y,
   output pix_ctl_type        out_ctl,
   output logic [WORD_AW-1:0] out_word,
   output logic [4:0]         out_bit,
   output logic               busy
);

   logic              s1_vld_ff, s1_vld_in;
   logic              s1_on_ff, s1_on_in;
   pix_tag_type       s1_tag_ff;
   logic [XW-1:0]     s1_x_ff;
   logic [YW-1:0]     s1_y_ff;
   logic              s2_vld_ff;
   logic              s2_on_ff;
   pix_tag_type       s2_tag_ff;
   logic [IDX_W-1:0]  s2_idx_ff, s2_idx_in;
   logic [12:0]       scr_x;
   logic [16:0]       scr_y;

   // Stage 1: screen position and clip test.
   always_comb begin
      scr_x     = 13'(base_x) + 13'(off_x);
      scr_y     = 17'(base_y) + 17'(off_y);
      s1_on_in  = (scr_x < 13'(SCREEN_WIDTH)) && (scr_y < 17'(SCREEN_HEIGHT));
      s1_vld_in = in_vld;
   end

   // Stage 2: linear pixel index, row times screen width plus column.
   assign s2_idx_in = IDX_W'(s1_y_ff) * IDX_W'(SCREEN_WIDTH) + IDX_W'(s1_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_on_ff  <= s1_on_in;
      s1_tag_ff <= in_tag;
      s1_x_ff   <= scr_x[XW-1:0];
      s1_y_ff   <= scr_y[YW-1:0];
      s2_on_ff  <= s1_on_ff;
      s2_tag_ff <= s1_tag_ff;
      s2_idx_ff <= s2_idx_in;
   end

   assign out_ctl.vld       = s2_vld_ff;
   assign out_ctl.on_screen = s2_on_ff;
   assign out_ctl.tag       = s2_tag_ff;
   assign out_word          = s2_idx_ff[5 +: WORD_AW];
   assign out_bit           = s2_idx_ff[4:0];
   assign busy              = s1_vld_ff | s2_vld_ff;

endmodule

// ===== hw/rtl/rle_bitmap_blit_with_clip_core.sv =====
// ----------------------------------------------------------------------------
// rle_bitmap_blit_with_clip_core: run-length monochrome bitmap blit with clip
// After reset the core sweeps the screen store clear, one 32-pixel word per
// cycle (STORE_WORDS words, 4800 at the default 480 x 320 screen), and
// holds req_stall high until the sweep is done. It then takes one request at
// a time. A run request places its pixels one per cycle through the shared
// address pipeline; once the pipeline has drained, its response is loaded
// into the output register when that register is free. A fetch request reads
// one window pixel through the same pipeline and the store's registered read
// port, or reads nothing when the window is empty. A finished response waits
// in an output register, and the next request is accepted while it waits.
// Configuration writes are taken in any cycle and must only be issued while
// the core is idle.
// ----------------------------------------------------------------------------
module rle_bitmap_blit_with_clip_core
   import rbb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIX_TOTAL   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int STORE_WORDS = (PIX_TOTAL + 31) / 32;
   localparam int WORD_AW     = $clog2(STORE_WORDS);

   // Configuration registers.
   logic [11:0] origin_x_ff, origin_y_ff, image_width_ff, image_height_ff;
   logic        overwrite_mode_ff;
   logic [7:0]  on_color_ff, off_color_ff;

   // Sequencer and item state.
   blit_state_type     state_ff, state_in;
   logic [WORD_AW-1:0] clr_addr_ff, clr_addr_in;
   logic               op_ff, op_in;
   logic [7:0]         run_left_ff, run_left_in;
   logic               last_run_ff, last_run_in;
   logic               run_is_on_ff, run_is_on_in;
   logic [11:0]        image_column_ff, image_column_in;
   logic [15:0]        image_row_ff, image_row_in;
   logic [17:0]        placed_count_ff, placed_count_in;
   logic [11:0]        fetch_column_ff, fetch_column_in;
   logic [11:0]        fetch_row_ff, fetch_row_in;
   logic               win_last_ff, win_last_in;
   logic               pix_bit_ff, pix_bit_in;
   logic               rd_vld_ff;
   logic [4:0]         rd_bit_ff;

   // Clipped window, derived from the configuration.
   logic [12:0] win_w_ff, win_w_in, win_h_ff, win_h_in;
   logic        win_empty_ff, win_empty_in;
   logic [12:0] eff_w, eff_h;

   // Response register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Sequencer outputs.
   logic clr_en, accept, issue_run, issue_fetch, load_rsp, out_free;

   // Address pipeline and memory signals.
   pix_tag_type        issue_tag;
   logic [11:0]        issue_x;
   logic [15:0]        issue_y;
   pix_ctl_type        pipe_ctl;
   logic [WORD_AW-1:0] pipe_word;
   logic [4:0]         pipe_bit;
   logic               pipe_busy;
   logic               mem_wr_en, mem_rd_en;
   logic [WORD_AW-1:0] mem_wr_addr;
   logic [31:0]        mem_wr_mask, mem_wr_data, mem_rd_data;
   logic               count_evt;
   logic [12:0]        col_nx, fcol_nx, frow_nx;
   logic [7:0]         color_byte;

   // Configuration port; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff       <= '0;
         origin_y_ff       <= '0;
         image_width_ff    <= 12'd1;
         image_height_ff   <= 12'd1;
         overwrite_mode_ff <= 1'b0;
         on_color_ff       <= 8'hFF;
         off_color_ff      <= 8'h00;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X:       origin_x_ff       <= csr_wdata;
            CSR_ORIGIN_Y:       origin_y_ff       <= csr_wdata;
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wdata;
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata;
            CSR_OVERWRITE_MODE: overwrite_mode_ff <= csr_wdata[0];
            CSR_ON_COLOR:       on_color_ff       <= csr_wdata[7:0];
            CSR_OFF_COLOR:      off_color_ff      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Window geometry: image size clipped to the screen edge.
   always_comb begin
      eff_w = (image_width_ff == '0) ? SIZE_ZERO_AS : {1'b0, image_width_ff};
      eff_h = (image_height_ff == '0) ? SIZE_ZERO_AS : {1'b0, image_height_ff};
      win_w_in = 13'(SCREEN_WIDTH) - {1'b0, origin_x_ff};
      if (eff_w < win_w_in) begin
         win_w_in = eff_w;
      end
      win_h_in = 13'(SCREEN_HEIGHT) - {1'b0, origin_y_ff};
      if (eff_h < win_h_in) begin
         win_h_in = eff_h;
      end
      win_empty_in = ({1'b0, origin_x_ff} >= 13'(SCREEN_WIDTH)) ||
                     ({1'b0, origin_y_ff} >= 13'(SCREEN_HEIGHT));
   end

   always_ff @(posedge clock) begin
      win_w_ff     <= win_w_in;
      win_h_ff     <= win_h_in;
      win_empty_ff <= win_empty_in;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == WORD_AW'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_payload.op == OP_RUN) ? ST_RUN : ST_FETCH;
            end
         end
         ST_RUN: begin
            if (run_left_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: begin
            state_in = win_empty_ff ? ST_DONE : ST_FETCH_ISSUE;
         end
         ST_FETCH_ISSUE: begin
            state_in = ST_FETCH_WAIT;
         end
         ST_FETCH_WAIT: begin
            if (rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      clr_en      = (state_ff == ST_CLEAR);
      accept      = (state_ff == ST_IDLE) && req_valid;
      issue_run   = (state_ff == ST_RUN) && (run_left_ff != '0);
      issue_fetch = (state_ff == ST_FETCH_ISSUE);
      load_rsp    = (state_ff == ST_DONE) && out_free;
   end

   // Pixel issue into the shared address pipeline.
   always_comb begin
      if (issue_fetch) begin
         issue_x   = fetch_column_ff;
         issue_y   = {4'b0, fetch_row_ff};
         issue_tag = '{is_run: 1'b0, wr_en: 1'b0, wr_bit: 1'b0};
      end else begin
         issue_x   = image_column_ff;
         issue_y   = image_row_ff;
         issue_tag = '{is_run: 1'b1, wr_en: run_is_on_ff | overwrite_mode_ff,
                       wr_bit: run_is_on_ff};
      end
   end

   rbb_addr_unit #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_addr (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (issue_run | issue_fetch),
      .in_tag   (issue_tag),
      .base_x   (origin_x_ff),
      .base_y   (origin_y_ff),
      .off_x    (issue_x),
      .off_y    (issue_y),
      .out_ctl  (pipe_ctl),
      .out_word (pipe_word),
      .out_bit  (pipe_bit),
      .busy     (pipe_busy)
   );

   // Store port: clearing sweep or a pixel write from the pipeline.
   always_comb begin
      count_evt = pipe_ctl.vld && pipe_ctl.on_screen && pipe_ctl.tag.is_run;
      mem_rd_en = pipe_ctl.vld && pipe_ctl.on_screen && !pipe_ctl.tag.is_run;
      if (clr_en) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_mask = '1;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = count_evt && pipe_ctl.tag.wr_en;
         mem_wr_addr = pipe_word;
         mem_wr_mask = 32'd1 << pipe_bit;
         mem_wr_data = {32{pipe_ctl.tag.wr_bit}};
      end
   end

   rbb_screen_mem #(
      .DEPTH (STORE_WORDS),
      .AW    (WORD_AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_mask (mem_wr_mask),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (pipe_word),
      .rd_data (mem_rd_data)
   );

   // Datapath next values.
   always_comb begin
      clr_addr_in     = clr_addr_ff;
      op_in           = op_ff;
      run_left_in     = run_left_ff;
      last_run_in     = last_run_ff;
      run_is_on_in    = run_is_on_ff;
      image_column_in = image_column_ff;
      image_row_in    = image_row_ff;
      placed_count_in = placed_count_ff;
      fetch_column_in = fetch_column_ff;
      fetch_row_in    = fetch_row_ff;
      win_last_in     = win_last_ff;
      pix_bit_in      = pix_bit_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      col_nx          = {1'b0, image_column_ff} + 13'd1;
      fcol_nx         = {1'b0, fetch_column_ff} + 13'd1;
      frow_nx         = {1'b0, fetch_row_ff} + 13'd1;
      color_byte      = pix_bit_ff ? on_color_ff : off_color_ff;

      if (clr_en) begin
         clr_addr_in = clr_addr_ff + WORD_AW'(1);
      end

      // Request capture.
      if (accept) begin
         op_in       = req_payload.op;
         run_left_in = req_payload.run_length;
         last_run_in = req_payload.last_run;
      end

      // Run placement: step the image position one pixel per cycle.
      if (issue_run) begin
         run_left_in = run_left_ff - 8'd1;
         if (col_nx >= eff_w) begin
            image_column_in = '0;
            if (image_row_ff != ROW_MAX) begin
               image_row_in = image_row_ff + 16'd1;
            end
         end else begin
            image_column_in = col_nx[11:0];
         end
      end

      // Placed pixel count, saturating.
      if (count_evt && (placed_count_ff != COUNT_MAX)) begin
         placed_count_in = placed_count_ff + 18'd1;
      end

      // Fetch: restart when the position lies outside the window.
      if ((state_ff == ST_FETCH) && !win_empty_ff) begin
         if (({1'b0, fetch_column_ff} >= win_w_ff) ||
             ({1'b0, fetch_row_ff} >= win_h_ff)) begin
            fetch_column_in = '0;
            fetch_row_in    = '0;
         end
      end

      // Fetch: mark the window end and advance in raster order.
      if (issue_fetch) begin
         win_last_in = ({1'b0, fetch_column_ff} == win_w_ff - 13'd1) &&
                       ({1'b0, fetch_row_ff} == win_h_ff - 13'd1);
         if (fcol_nx >= win_w_ff) begin
            fetch_column_in = '0;
            fetch_row_in    = (frow_nx >= win_h_ff) ? '0 : frow_nx[11:0];
         end else begin
            fetch_column_in = fcol_nx[11:0];
         end
      end

      if (rd_vld_ff) begin
         pix_bit_in = mem_rd_data[rd_bit_ff];
      end

      // Response register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.pixels_drawn = placed_count_ff;
         if (op_ff == OP_RUN) begin
            rsp_payload_in.pixel_color = '0;
            rsp_payload_in.window_last = 1'b0;
            if (last_run_ff) begin
               run_is_on_in    = 1'b0;
               image_column_in = '0;
               image_row_in    = '0;
               placed_count_in = '0;
               fetch_column_in = '0;
               fetch_row_in    = '0;
            end else begin
               run_is_on_in = !run_is_on_ff;
            end
         end else if (win_empty_ff) begin
            rsp_payload_in.pixel_color = '0;
            rsp_payload_in.window_last = 1'b1;
         end else begin
            rsp_payload_in.pixel_color = {color_byte, color_byte};
            rsp_payload_in.window_last = win_last_ff;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         run_is_on_ff    <= 1'b0;
         image_column_ff <= '0;
         image_row_ff    <= '0;
         placed_count_ff <= '0;
         fetch_column_ff <= '0;
         fetch_row_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         rd_vld_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         run_is_on_ff    <= run_is_on_in;
         image_column_ff <= image_column_in;
         image_row_ff    <= image_row_in;
         placed_count_ff <= placed_count_in;
         fetch_column_ff <= fetch_column_in;
         fetch_row_ff    <= fetch_row_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_vld_ff       <= mem_rd_en;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      run_left_ff    <= run_left_in;
      last_run_ff    <= last_run_in;
      win_last_ff    <= win_last_in;
      pix_bit_ff     <= pix_bit_in;
      rd_bit_ff      <= pipe_bit;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // No pipeline pixel may reach the store while the clearing sweep runs.
   a_no_pixel_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !pipe_ctl.vld)
      else $error("pixel left the address pipeline during the clearing sweep");

   // Read data only comes back while a fetch is waiting for it.
   a_read_in_fetch: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_FETCH_WAIT))
      else $error("store read returned outside a fetch");

   // The placed count only drops at the end of an image.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> (placed_count_ff >= $past(placed_count_ff)))
      else $error("placed pixel count decreased mid-image");

   // Finishing a request always presents a response.
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("finished request did not present a response");

endmodule
